// ===== design/assert_macros.svh =====
// Assertion macros used by the checker file of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("%m: assertion failed");

// Condition that must never be true at a rising clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
	else $error("%m: forbidden condition seen");

`endif

// ===== design/ped_pkg.sv =====
// Shared types and constants of the pheromone evaporate and deposit block.
package ped_pkg;

	localparam int LEVEL_W  = 24;
	localparam int RETAIN_W = 17;
	localparam int COST_W   = 24;
	localparam int NODE_W   = 7;
	localparam int COUNT_W  = 8;
	localparam int QUOT_W   = 17;
	localparam int PROD_W   = LEVEL_W + RETAIN_W;
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int DIV_CNT_W = 5;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 5'd17;
	localparam logic [QUOT_W-1:0] DIV_DIVIDEND = 17'h10000;
	localparam logic [LEVEL_W-1:0] LEVEL_MAX = 24'hFFFFFF;

	localparam logic [1:0] FUNC_INIT    = 2'd0;
	localparam logic [1:0] FUNC_EVAP    = 2'd1;
	localparam logic [1:0] FUNC_DEPOSIT = 2'd2;
	localparam logic [1:0] FUNC_READ    = 2'd3;

	localparam logic [1:0] REG_NODE_COUNT    = 2'd0;
	localparam logic [1:0] REG_RETAIN_FACTOR = 2'd1;
	localparam logic [1:0] REG_LEVEL_FLOOR   = 2'd2;
	localparam logic [1:0] REG_LEVEL_CEILING = 2'd3;

	typedef struct packed {
		logic [COUNT_W-1:0]  node_count;
		logic [RETAIN_W-1:0] retain_factor;
		logic [LEVEL_W-1:0]  level_floor;
		logic [LEVEL_W-1:0]  level_ceiling;
	} ped_cfg_t;

	typedef struct packed {
		logic load;
		logic init_wr;
		logic ev_mul;
		logic ev_wr;
		logic rd_cap;
		logic dep_wr;
	} ped_cmd_t;

	typedef struct packed {
		logic [1:0] func;
		logic       empty;
		logic       bad;
		logic       last;
		logic       div_busy;
	} ped_stat_t;

endpackage

// ===== design/ped_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module ped_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 16384
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/ped_ctrl.sv =====
// Controller state machine that sequences sweeps, reads and deposits.
module ped_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  ped_pkg::ped_stat_t stat,
	output ped_pkg::ped_cmd_t  cmd,
	output logic               busy,
	output logic               done
);

	import ped_pkg::*;

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_DECODE  = 4'd1;
	localparam logic [3:0] S_INIT_WR = 4'd2;
	localparam logic [3:0] S_EV_RD   = 4'd3;
	localparam logic [3:0] S_EV_MUL  = 4'd4;
	localparam logic [3:0] S_EV_WR   = 4'd5;
	localparam logic [3:0] S_AD_RD   = 4'd6;
	localparam logic [3:0] S_AD_DATA = 4'd7;
	localparam logic [3:0] S_DONE    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_DECODE;
				end
			end
			S_DECODE: begin
				if (stat.func == FUNC_INIT) begin
					state_d = stat.empty ? S_DONE : S_INIT_WR;
				end else if (stat.func == FUNC_EVAP) begin
					state_d = stat.empty ? S_DONE : S_EV_RD;
				end else begin
					state_d = stat.bad ? S_DONE : S_AD_RD;
				end
			end
			S_INIT_WR: begin
				cmd.init_wr = 1'b1;
				if (stat.last) begin
					state_d = S_DONE;
				end
			end
			S_EV_RD: begin
				state_d = S_EV_MUL;
			end
			S_EV_MUL: begin
				cmd.ev_mul = 1'b1;
				state_d    = S_EV_WR;
			end
			S_EV_WR: begin
				cmd.ev_wr = 1'b1;
				state_d   = stat.last ? S_DONE : S_EV_RD;
			end
			S_AD_RD: begin
				state_d = S_AD_DATA;
			end
			S_AD_DATA: begin
				if (stat.func == FUNC_READ) begin
					cmd.rd_cap = 1'b1;
					state_d    = S_DONE;
				end else if (!stat.div_busy) begin
					cmd.dep_wr = 1'b1;
					state_d    = S_DONE;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule

// ===== design/ped_dp.sv =====
// Datapath with the level table, sweep counters, multiplier and reciprocal divider.
module ped_dp #(
	parameter int NODES = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  ped_pkg::ped_cmd_t             cmd,
	input  ped_pkg::ped_cfg_t             cfg,
	input  logic [1:0]                    func,
	input  logic [ped_pkg::NODE_W-1:0]    from_node,
	input  logic [ped_pkg::NODE_W-1:0]    to_node,
	input  logic [ped_pkg::COST_W-1:0]    tour_cost,
	output ped_pkg::ped_stat_t            stat,
	output logic [ped_pkg::LEVEL_W-1:0]   level,
	output logic                          bad_node
);

	import ped_pkg::*;

	localparam int IW     = (NODES > 1) ? $clog2(NODES) : 1;
	localparam int CLOG_N = $clog2(NODES + 1);
	localparam int NW     = (CLOG_N > COUNT_W) ? CLOG_N : COUNT_W;
	localparam int DEPTH  = NODES * NODES;
	localparam int ADDR_W = $clog2(DEPTH);

	logic [NW-1:0]       act_n;
	logic [IW-1:0]       i_q;
	logic [IW-1:0]       j_q;
	logic [ADDR_W-1:0]   addr;
	logic [1:0]          func_q;
	logic                bad_q;
	logic [COST_W-1:0]   cost_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [LEVEL_W-1:0]  rdata;
	logic [PROD_W-1:0]   prod_s1;
	logic [LEVEL_W:0]    ev_shift;
	logic [LEVEL_W-1:0]  ev_sat;
	logic [LEVEL_W-1:0]  ev_val;
	logic [LEVEL_W:0]    dep_sum;
	logic [LEVEL_W-1:0]  dep_val;
	logic                we;
	logic [LEVEL_W-1:0]  wdata;
	logic                j_last;
	logic                i_last;
	logic                addressed;
	logic                load_bad;
	logic [DIV_CNT_W-1:0] div_cnt_q;
	logic [COST_W-1:0]   rem_q;
	logic [QUOT_W-1:0]   quo_q;
	logic [QUOT_W-1:0]   dvd_q;
	logic [COST_W:0]     rem_sh;
	logic [COST_W:0]     rem_sub;
	logic                rem_ge;

	assign act_n = (NW'(cfg.node_count) >= NW'(NODES)) ? NW'(NODES) : NW'(cfg.node_count);

	assign addressed = (func == FUNC_DEPOSIT) || (func == FUNC_READ);
	assign load_bad  = addressed && ((NW'(from_node) >= act_n) || (NW'(to_node) >= act_n));

	assign j_last = ((NW'(j_q) + NW'(1)) == act_n);
	assign i_last = ((NW'(i_q) + NW'(1)) == act_n);
	assign addr   = ADDR_W'(i_q) * ADDR_W'(NODES) + ADDR_W'(j_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			i_q    <= '0;
			j_q    <= '0;
			func_q <= FUNC_INIT;
		end else if (cmd.load) begin
			func_q <= func;
			if (addressed) begin
				i_q <= IW'(from_node);
				j_q <= IW'(to_node);
			end else begin
				i_q <= '0;
				j_q <= '0;
			end
		end else if (cmd.init_wr || cmd.ev_wr) begin
			if (j_last) begin
				j_q <= '0;
				i_q <= i_q + IW'(1);
			end else begin
				j_q <= j_q + IW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			bad_q   <= load_bad;
			cost_q  <= tour_cost;
			level_q <= '0;
		end else if (cmd.rd_cap) begin
			level_q <= rdata;
		end else if (cmd.dep_wr) begin
			level_q <= dep_val;
		end
		if (cmd.ev_mul) begin
			prod_s1 <= PROD_W'(rdata) * PROD_W'(cfg.retain_factor);
		end
	end

	assign rem_sh  = {rem_q, dvd_q[QUOT_W-1]};
	assign rem_ge  = (rem_sh >= {1'b0, cost_q});
	assign rem_sub = rem_sh - {1'b0, cost_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_cnt_q <= '0;
		end else if (cmd.load) begin
			div_cnt_q <= DIV_STEPS;
		end else if (div_cnt_q != '0) begin
			div_cnt_q <= div_cnt_q - DIV_CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= DIV_DIVIDEND;
		end else if (div_cnt_q != '0) begin
			dvd_q <= {dvd_q[QUOT_W-2:0], 1'b0};
			quo_q <= {quo_q[QUOT_W-2:0], rem_ge};
			rem_q <= rem_ge ? rem_sub[COST_W-1:0] : rem_sh[COST_W-1:0];
		end
	end

	assign ev_shift = prod_s1[PROD_W-1:16];
	assign ev_sat   = ev_shift[LEVEL_W] ? LEVEL_MAX : ev_shift[LEVEL_W-1:0];
	assign ev_val   = (ev_sat < cfg.level_floor) ? cfg.level_floor : ev_sat;

	assign dep_sum = {1'b0, rdata} + (LEVEL_W + 1)'(quo_q);
	always_comb begin
		if (cost_q == '0) begin
			dep_val = cfg.level_ceiling;
		end else if (dep_sum > {1'b0, cfg.level_ceiling}) begin
			dep_val = cfg.level_ceiling;
		end else begin
			dep_val = dep_sum[LEVEL_W-1:0];
		end
	end

	assign we = cmd.init_wr || cmd.ev_wr || cmd.dep_wr;
	always_comb begin
		if (cmd.init_wr) begin
			wdata = cfg.level_ceiling;
		end else if (cmd.ev_wr) begin
			wdata = ev_val;
		end else begin
			wdata = dep_val;
		end
	end

	ped_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (addr),
		.wdata (wdata),
		.raddr (addr),
		.rdata (rdata)
	);

	assign stat.func     = func_q;
	assign stat.empty    = (act_n == '0);
	assign stat.bad      = bad_q;
	assign stat.last     = i_last && j_last;
	assign stat.div_busy = (div_cnt_q != '0);

	assign level    = level_q;
	assign bad_node = bad_q;

endmodule

// ===== design/pheromone_evaporate_deposit_top.sv =====
// Top level of the pheromone evaporate and deposit block with its register port.
// Steps from the accepting edge to the done strobe, with n = min(node_count, NODES):
// read fetches the entry; deposit waits on the 17-step reciprocal divider; initialize
// writes n*n entries (one table write per cycle); evaporate reads, multiplies, writes each.
// One item is in work at a time; a new start is taken the cycle after done.
// Reset idles the controller and loads the registers with their defaults; table is undefined.
module pheromone_evaporate_deposit_top #(
	parameter int NODES = 128
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    func,
	input  logic [ped_pkg::NODE_W-1:0]    from_node,
	input  logic [ped_pkg::NODE_W-1:0]    to_node,
	input  logic [ped_pkg::COST_W-1:0]    tour_cost,
	output logic                          done,
	output logic [ped_pkg::LEVEL_W-1:0]   level,
	output logic                          bad_node,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [ped_pkg::PADDR_W-1:0]   paddr,
	input  logic [ped_pkg::PDATA_W-1:0]   pwdata,
	output logic [ped_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);

	import ped_pkg::*;

	ped_cfg_t  cfg_q;
	ped_cmd_t  cmd;
	ped_stat_t stat;
	logic      reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.node_count    <= 8'd100;
			cfg_q.retain_factor <= 17'd32768;
			cfg_q.level_floor   <= 24'd6554;
			cfg_q.level_ceiling <= 24'd655360;
		end else if (reg_wr) begin
			unique case (paddr[3:2])
				REG_NODE_COUNT:    cfg_q.node_count    <= pwdata[COUNT_W-1:0];
				REG_RETAIN_FACTOR: cfg_q.retain_factor <= pwdata[RETAIN_W-1:0];
				REG_LEVEL_FLOOR:   cfg_q.level_floor   <= pwdata[LEVEL_W-1:0];
				REG_LEVEL_CEILING: cfg_q.level_ceiling <= pwdata[LEVEL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_NODE_COUNT:    prdata = PDATA_W'(cfg_q.node_count);
			REG_RETAIN_FACTOR: prdata = PDATA_W'(cfg_q.retain_factor);
			REG_LEVEL_FLOOR:   prdata = PDATA_W'(cfg_q.level_floor);
			REG_LEVEL_CEILING: prdata = PDATA_W'(cfg_q.level_ceiling);
			default:           prdata = '0;
		endcase
	end

	ped_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	ped_dp #(
		.NODES (NODES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg       (cfg_q),
		.func      (func),
		.from_node (from_node),
		.to_node   (to_node),
		.tour_cost (tour_cost),
		.stat      (stat),
		.level     (level),
		.bad_node  (bad_node)
	);

endmodule

// ===== design/ped_checker.sv =====
// Port-level checker for the pheromone block and its bind to the top level.
`include "assert_macros.svh"

module ped_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [23:0] level,
	input logic        bad_node,
	input logic        pready
);

	`ASSERT_CLK(a_accept_busy, clk, arst_n, (start && !busy) |=> busy)
	`ASSERT_CLK(a_done_in_busy, clk, arst_n, done |-> busy)
	`ASSERT_CLK(a_done_then_idle, clk, arst_n, done |=> !busy)
	`ASSERT_NEVER(a_bad_level_zero, clk, arst_n, done && bad_node && (level != 24'd0))
	`ASSERT_CLK(a_pready_high, clk, arst_n, pready)

endmodule

bind pheromone_evaporate_deposit_top ped_checker u_ped_checker (.*);

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the pheromone evaporate and deposit block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ped_pkg::*;

	localparam int NODE_LIMIT = 128;
	localparam int LEVEL_ONE = 65536;
	localparam int QUIET_LIMIT = 200000;

	typedef struct packed {
		logic [LEVEL_W-1:0] level;
		logic               bad_node;
	} op_result_t;

	class pheromone_checker;
		logic [LEVEL_W-1:0]  levels [NODE_LIMIT*NODE_LIMIT];
		logic [COUNT_W-1:0]  node_count;
		logic [RETAIN_W-1:0] retain;
		logic [LEVEL_W-1:0]  floor_lvl;
		logic [LEVEL_W-1:0]  ceil_lvl;
		op_result_t          expected_levels [$];
		int                  failures;

		function new();
			node_count = 8'd100;
			retain = 17'd32768;
			floor_lvl = 24'd6554;
			ceil_lvl = 24'd655360;
			failures = 0;
		endfunction

		function int active();
			return (node_count > NODE_LIMIT) ? NODE_LIMIT : int'(node_count);
		endfunction

		function int outstanding();
			return expected_levels.size();
		endfunction

		function void set_reg(logic [1:0] idx, logic [31:0] val);
			case (idx)
			REG_NODE_COUNT: node_count = val[COUNT_W-1:0];
			REG_RETAIN_FACTOR: retain = val[RETAIN_W-1:0];
			REG_LEVEL_FLOOR: floor_lvl = val[LEVEL_W-1:0];
			REG_LEVEL_CEILING: ceil_lvl = val[LEVEL_W-1:0];
			default: ;
			endcase
		endfunction

		function void log_failure(string msg);
			failures++;
			if (failures <= 10)
				$display("%s", msg);
		endfunction

		function void note_op(logic [1:0] op, logic [NODE_W-1:0] src,
				logic [NODE_W-1:0] dst, logic [COST_W-1:0] cost);
			int                     n;
			int                     idx;
			int                     quot;
			logic [PROD_W-1:0]      prod;
			logic [LEVEL_W:0]       sum;
			logic [LEVEL_W-1:0]     lvl;
			op_result_t             res;
			n = active();
			res = '0;
			case (op)
			FUNC_INIT: begin
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++)
						levels[i*NODE_LIMIT+j] = ceil_lvl;
			end
			FUNC_EVAP: begin
				for (int i = 0; i < n; i++) begin
					for (int j = 0; j < n; j++) begin
						idx = i*NODE_LIMIT + j;
						prod = levels[idx] * retain;
						if (prod[PROD_W-1:16] > {1'b0, {LEVEL_W{1'b1}}})
							lvl = {LEVEL_W{1'b1}};
						else
							lvl = prod[LEVEL_W+15:16];
						if (lvl < floor_lvl)
							lvl = floor_lvl;
						levels[idx] = lvl;
					end
				end
			end
			default: begin
				if (src >= n || dst >= n) begin
					res.bad_node = 1'b1;
				end else begin
					idx = int'(src)*NODE_LIMIT + int'(dst);
					if (op == FUNC_DEPOSIT) begin
						if (cost == '0) begin
							sum = {1'b0, ceil_lvl};
						end else begin
							quot = LEVEL_ONE / int'(cost);
							sum = (LEVEL_W+1)'(levels[idx]) + (LEVEL_W+1)'(quot);
						end
						if (sum > {1'b0, ceil_lvl})
							sum = {1'b0, ceil_lvl};
						levels[idx] = sum[LEVEL_W-1:0];
					end
					res.level = levels[idx];
				end
			end
			endcase
			expected_levels.push_back(res);
		endfunction

		function void check_result(logic [LEVEL_W-1:0] got_level, logic got_bad);
			op_result_t want;
			if (expected_levels.size() == 0) begin
				log_failure($sformatf("Result with no transfer pending: level=%06h bad_node=%0b",
					got_level, got_bad));
				return;
			end
			want = expected_levels.pop_front();
			if (got_level !== want.level || got_bad !== want.bad_node)
				log_failure($sformatf({"Mismatch: expected level=%06h bad_node=%0b, ",
					"got level=%06h bad_node=%0b"},
					want.level, want.bad_node, got_level, got_bad));
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                start = 1'b0;
	logic [1:0]          func = '0;
	logic [NODE_W-1:0]   from_node = '0;
	logic [NODE_W-1:0]   to_node = '0;
	logic [COST_W-1:0]   tour_cost = '0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic                busy;
	logic                done;
	logic [LEVEL_W-1:0]  level;
	logic                bad_node;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	pheromone_checker sb;
	int               idle_pct = 0;
	int               init_span = 0;
	int               quiet_cycles = 0;
	int               idle_levels [3] = '{0, 51, 8};

	pheromone_evaporate_deposit_top #(
		.NODES(NODE_LIMIT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.from_node(from_node),
		.to_node(to_node),
		.tour_cost(tour_cost),
		.done(done),
		.level(level),
		.bad_node(bad_node),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done !== 1'b0)
			sb.check_result(level, bad_node);
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("[pheromone_evaporate_deposit_top] ERROR");
		$finish;
	end

	task automatic send_op(input logic [1:0] op, input int src, input int dst,
			input logic [COST_W-1:0] cost);
		while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			func <= 2'($urandom);
			from_node <= NODE_W'($urandom);
			to_node <= NODE_W'($urandom);
			tour_cost <= COST_W'($urandom);
			@(posedge clk);
		end
		start <= 1'b1;
		func <= op;
		from_node <= NODE_W'(src);
		to_node <= NODE_W'(dst);
		tour_cost <= cost;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		if (op == FUNC_INIT && sb.active() > init_span)
			init_span = sb.active();
		sb.note_op(op, NODE_W'(src), NODE_W'(dst), cost);
	endtask

	task automatic drain();
		start <= 1'b0;
		while (sb.outstanding() > 0)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		sb.set_reg(idx, val);
	endtask

	task automatic set_config(input logic [COUNT_W-1:0] nc, input logic [RETAIN_W-1:0] ret,
			input logic [LEVEL_W-1:0] flo, input logic [LEVEL_W-1:0] cei);
		drain();
		write_reg(REG_NODE_COUNT, 32'(nc));
		write_reg(REG_RETAIN_FACTOR, 32'(ret));
		write_reg(REG_LEVEL_FLOOR, 32'(flo));
		write_reg(REG_LEVEL_CEILING, 32'(cei));
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic run_random_phase(input int n_items);
		logic [COUNT_W-1:0]  nc;
		logic [RETAIN_W-1:0] ret;
		logic [LEVEL_W-1:0]  flo;
		logic [LEVEL_W-1:0]  cei;
		logic [COST_W-1:0]   cost;
		logic [1:0]          op;
		int                  r;
		int                  n;
		int                  src;
		int                  dst;
		r = $urandom_range(19);
		if (r < 12)
			nc = COUNT_W'($urandom_range(2, 12));
		else if (r < 14)
			nc = COUNT_W'($urandom_range(1));
		else if (r < 19)
			nc = COUNT_W'($urandom_range(13, 32));
		else
			nc = COUNT_W'($urandom_range(33, 64));
		case ($urandom_range(7))
		0: ret = '0;
		1: ret = RETAIN_W'(LEVEL_ONE);
		2: ret = RETAIN_W'($urandom);
		default: ret = RETAIN_W'($urandom_range(16384, LEVEL_ONE));
		endcase
		case ($urandom_range(5))
		0: flo = '0;
		1: flo = LEVEL_W'($urandom);
		default: flo = LEVEL_W'($urandom_range(32768));
		endcase
		case ($urandom_range(7))
		0: cei = '1;
		1: cei = '0;
		2: cei = LEVEL_W'($urandom_range(65535));
		3: cei = LEVEL_W'($urandom);
		default: cei = LEVEL_W'($urandom_range(65536, 24'h100000));
		endcase
		set_config(nc, ret, flo, cei);
		n = sb.active();
		for (int k = 0; k < n_items; k++) begin
			r = $urandom_range(19);
			if (k == 0 || r == 0)
				op = FUNC_INIT;
			else if (r < 4)
				op = FUNC_EVAP;
			else if (r < 12)
				op = FUNC_DEPOSIT;
			else
				op = FUNC_READ;
			if (n > 0 && $urandom_range(9) != 0) begin
				src = $urandom_range(n - 1);
				dst = $urandom_range(n - 1);
			end else begin
				src = $urandom_range(127);
				dst = $urandom_range(127);
			end
			case ($urandom_range(9))
			0: cost = '0;
			1: cost = COST_W'($urandom);
			2: cost = COST_W'($urandom_range(1, 16));
			3, 4: cost = COST_W'($urandom_range(1, 1024));
			default: cost = COST_W'($urandom_range(1, 70000));
			endcase
			// Entries not yet covered by an initialize must never be touched.
			if (op == FUNC_EVAP && n > init_span)
				op = FUNC_INIT;
			if ((op == FUNC_DEPOSIT || op == FUNC_READ) && src < n && dst < n &&
					(src >= init_span || dst >= init_span))
				op = FUNC_INIT;
			send_op(op, src, dst, cost);
		end
	endtask

	initial begin
		sb = new();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_op(FUNC_READ, 100, 0, '0);
		send_op(FUNC_INIT, 0, 0, '0);
		send_op(FUNC_DEPOSIT, 0, 0, 24'd1);
		send_op(FUNC_EVAP, 0, 0, '0);
		send_op(FUNC_DEPOSIT, 99, 99, '0);
		send_op(FUNC_DEPOSIT, 1, 2, 24'hFFFFFF);
		send_op(FUNC_DEPOSIT, 3, 3, 24'd65536);
		send_op(FUNC_READ, 127, 127, '0);

		set_config(8'd255, 17'd65536, '0, 24'hFFFFFF);
		send_op(FUNC_INIT, 0, 0, '0);
		send_op(FUNC_DEPOSIT, 127, 127, 24'd1);
		send_op(FUNC_EVAP, 0, 0, '0);
		send_op(FUNC_READ, 127, 0, '0);

		set_config(8'd0, 17'd32768, 24'd6554, 24'd655360);
		send_op(FUNC_EVAP, 0, 0, '0);
		send_op(FUNC_DEPOSIT, 0, 0, 24'd1);

		set_config(8'd1, 17'h1FFFF, '0, 24'hFFFFFF);
		send_op(FUNC_INIT, 0, 0, '0);
		send_op(FUNC_EVAP, 0, 0, '0);
		send_op(FUNC_READ, 0, 0, '0);

		set_config(8'd2, '0, 24'h123456, 24'h001000);
		send_op(FUNC_EVAP, 0, 0, '0);
		send_op(FUNC_DEPOSIT, 1, 1, 24'd3);
		send_op(FUNC_READ, 1, 0, '0);

		for (int ph = 0; ph < 12; ph++) begin
			idle_pct = idle_levels[ph % 3];
			run_random_phase(44);
		end

		drain();
		repeat (25)
			@(posedge clk);
		if (sb.failures == 0)
			$display("[pheromone_evaporate_deposit_top] OK");
		else
			$display("[pheromone_evaporate_deposit_top] ERROR");
		$finish;
	end
endmodule

// ===== filelist.f =====
+incdir+design
design/ped_pkg.sv
design/ped_ram.sv
design/ped_ctrl.sv
design/ped_dp.sv
design/pheromone_evaporate_deposit_top.sv
design/ped_checker.sv
tb/sv/tb.sv
